// ===== rtl/uart_rb_pkg.sv =====
// Shared constants, command codes and the stage payload type for the serial port ring buffers.
package uart_rb_pkg;

  localparam int RX_ADDR_BITS = 6;
  localparam int TX_ADDR_BITS = 6;
  localparam int DATA_W       = 8;
  localparam int CNT_W        = 6;
  localparam int CMD_W        = 3;
  localparam int LEN_W        = 8;

  localparam logic [RX_ADDR_BITS-1:0] RX_MASK = {RX_ADDR_BITS{1'b1}};
  localparam logic [TX_ADDR_BITS-1:0] TX_MASK = {TX_ADDR_BITS{1'b1}};

  typedef enum logic [CMD_W-1:0] {
    CMD_RX_BYTE  = 3'd0,
    CMD_TX_READY = 3'd1,
    CMD_HOST_RD  = 3'd2,
    CMD_HOST_WR  = 3'd3,
    CMD_STATUS   = 3'd4
  } cmd_e;

  typedef struct packed {
    logic             tx_valid;
    logic             tx_irq_enabled;
    logic             read_valid;
    logic             send_accepted;
    logic             rx_overrun;
    logic [CNT_W-1:0] rx_available;
    logic [CNT_W-1:0] rx_space;
    logic [CNT_W-1:0] tx_space;
  } stage_t;

endpackage

// ===== rtl/uart_rb_ram.sv =====
// Generic single-port RAM with a registered read.
module uart_rb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/uart_rx_tx_ring_buffers.sv =====
// Top level of the serial port receive and transmit ring buffers.
// out_valid_o comes from the output register, fed by stage s1 and the RAM read.
// Throughput: one item per cycle while the output side does not stall.
// Pointers update at the input transfer, so the next item sees them at once.
// Reset (rst_ni low, asynchronous) clears pointers, flags and valid bits.
// RAM contents are not cleared; only written entries are ever read.
module uart_rx_tx_ring_buffers (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [uart_rb_pkg::CMD_W-1:0]  command_i,
  input  logic [uart_rb_pkg::DATA_W-1:0] data_byte_i,
  input  logic                         send_first_i,
  input  logic [uart_rb_pkg::LEN_W-1:0]  send_length_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [uart_rb_pkg::DATA_W-1:0] tx_data_o,
  output logic                         tx_valid_o,
  output logic                         tx_irq_enabled_o,
  output logic [uart_rb_pkg::DATA_W-1:0] read_data_o,
  output logic                         read_valid_o,
  output logic                         send_accepted_o,
  output logic                         rx_overrun_o,
  output logic [uart_rb_pkg::CNT_W-1:0]  rx_available_o,
  output logic [uart_rb_pkg::CNT_W-1:0]  rx_space_o,
  output logic [uart_rb_pkg::CNT_W-1:0]  tx_space_o
);

  logic [uart_rb_pkg::RX_ADDR_BITS-1:0] rx_head_q, rx_head_d, rx_tail_q, rx_tail_d;
  logic [uart_rb_pkg::TX_ADDR_BITS-1:0] tx_head_q, tx_head_d, tx_tail_q, tx_tail_d;
  logic [uart_rb_pkg::RX_ADDR_BITS-1:0] rx_cnt, rx_free, rx_cnt_nx, rx_free_nx, rx_addr;
  logic [uart_rb_pkg::TX_ADDR_BITS-1:0] tx_cnt, tx_free, tx_free_nx, tx_addr;
  logic irq_q, irq_d, batch_ok_q, batch_ok_d, send_ok;
  logic rx_we, rx_re, tx_we, tx_re;
  logic [uart_rb_pkg::DATA_W-1:0] rx_rdata, tx_rdata;

  logic                  s1_valid_q;
  uart_rb_pkg::stage_t   s1_q, s1_d;
  logic                  out_valid_q;
  uart_rb_pkg::stage_t   out_q;
  logic [uart_rb_pkg::DATA_W-1:0] out_tx_data_q, out_rd_data_q;
  logic in_xfer, s1_adv;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_xfer    = in_valid_i && !in_stall_o;

  assign rx_cnt  = rx_head_q - rx_tail_q;
  assign tx_cnt  = tx_head_q - tx_tail_q;
  assign rx_free = uart_rb_pkg::RX_MASK - rx_cnt;
  assign tx_free = uart_rb_pkg::TX_MASK - tx_cnt;

  always_comb begin
    rx_head_d  = rx_head_q;
    rx_tail_d  = rx_tail_q;
    tx_head_d  = tx_head_q;
    tx_tail_d  = tx_tail_q;
    irq_d      = irq_q;
    batch_ok_d = batch_ok_q;
    rx_we      = 1'b0;
    rx_re      = 1'b0;
    tx_we      = 1'b0;
    tx_re      = 1'b0;
    send_ok    = batch_ok_q;
    s1_d       = '0;
    if (in_xfer) begin
      case (command_i)
        uart_rb_pkg::CMD_RX_BYTE: begin
          if (rx_free == '0) begin
            s1_d.rx_overrun = 1'b1;
          end else begin
            rx_we     = 1'b1;
            rx_head_d = rx_head_q + 1'b1;
          end
        end
        uart_rb_pkg::CMD_TX_READY: begin
          if (tx_cnt == '0) begin
            irq_d = 1'b0;
          end else begin
            tx_re         = 1'b1;
            tx_tail_d     = tx_tail_q + 1'b1;
            s1_d.tx_valid = 1'b1;
          end
        end
        uart_rb_pkg::CMD_HOST_RD: begin
          if (rx_cnt != '0) begin
            rx_re           = 1'b1;
            rx_tail_d       = rx_tail_q + 1'b1;
            s1_d.read_valid = 1'b1;
          end
        end
        uart_rb_pkg::CMD_HOST_WR: begin
          if (send_first_i) begin
            send_ok    = (9'(send_length_i) <= 9'(tx_free));
            batch_ok_d = send_ok;
          end
          if (send_ok && (tx_free != '0)) begin
            tx_we              = 1'b1;
            tx_head_d          = tx_head_q + 1'b1;
            irq_d              = 1'b1;
            s1_d.send_accepted = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    rx_cnt_nx           = rx_head_d - rx_tail_d;
    rx_free_nx          = uart_rb_pkg::RX_MASK - rx_cnt_nx;
    tx_free_nx          = uart_rb_pkg::TX_MASK - (tx_head_d - tx_tail_d);
    s1_d.tx_irq_enabled = irq_d;
    s1_d.rx_available   = uart_rb_pkg::CNT_W'(rx_cnt_nx);
    s1_d.rx_space       = uart_rb_pkg::CNT_W'(rx_free_nx);
    s1_d.tx_space       = uart_rb_pkg::CNT_W'(tx_free_nx);
  end

  assign rx_addr = (command_i == uart_rb_pkg::CMD_RX_BYTE) ? rx_head_q : rx_tail_q;
  assign tx_addr = (command_i == uart_rb_pkg::CMD_HOST_WR) ? tx_head_q : tx_tail_q;

  uart_rb_ram #(
    .WIDTH(uart_rb_pkg::DATA_W),
    .DEPTH(1 << uart_rb_pkg::RX_ADDR_BITS)
  ) u_rx_ram (
    .clk_i  (clk_i),
    .we_i   (rx_we),
    .re_i   (rx_re),
    .addr_i (rx_addr),
    .wdata_i(data_byte_i),
    .rdata_o(rx_rdata)
  );

  uart_rb_ram #(
    .WIDTH(uart_rb_pkg::DATA_W),
    .DEPTH(1 << uart_rb_pkg::TX_ADDR_BITS)
  ) u_tx_ram (
    .clk_i  (clk_i),
    .we_i   (tx_we),
    .re_i   (tx_re),
    .addr_i (tx_addr),
    .wdata_i(data_byte_i),
    .rdata_o(tx_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rx_head_q   <= '0;
      rx_tail_q   <= '0;
      tx_head_q   <= '0;
      tx_tail_q   <= '0;
      irq_q       <= 1'b0;
      batch_ok_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rx_head_q  <= rx_head_d;
      rx_tail_q  <= rx_tail_d;
      tx_head_q  <= tx_head_d;
      tx_tail_q  <= tx_tail_d;
      irq_q      <= irq_d;
      batch_ok_q <= batch_ok_d;
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_q <= s1_d;
    end
    if (s1_adv) begin
      out_q         <= s1_q;
      out_tx_data_q <= s1_q.tx_valid ? tx_rdata : '0;
      out_rd_data_q <= s1_q.read_valid ? rx_rdata : '0;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign tx_data_o        = out_tx_data_q;
  assign tx_valid_o       = out_q.tx_valid;
  assign tx_irq_enabled_o = out_q.tx_irq_enabled;
  assign read_data_o      = out_rd_data_q;
  assign read_valid_o     = out_q.read_valid;
  assign send_accepted_o  = out_q.send_accepted;
  assign rx_overrun_o     = out_q.rx_overrun;
  assign rx_available_o   = out_q.rx_available;
  assign rx_space_o       = out_q.rx_space;
  assign tx_space_o       = out_q.tx_space;

endmodule

// ===== rtl/uart_rb_chk.sv =====
// Port-level checker for the serial port ring buffers, bound to the top level.
module uart_rb_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_stall_i,
  input logic [uart_rb_pkg::DATA_W-1:0] tx_data_o,
  input logic                         tx_valid_o,
  input logic                         tx_irq_enabled_o,
  input logic [uart_rb_pkg::DATA_W-1:0] read_data_o,
  input logic                         read_valid_o,
  input logic                         send_accepted_o,
  input logic                         rx_overrun_o,
  input logic [uart_rb_pkg::CNT_W-1:0]  rx_available_o,
  input logic [uart_rb_pkg::CNT_W-1:0]  rx_space_o,
  input logic [uart_rb_pkg::CNT_W-1:0]  tx_space_o
);

  localparam logic [uart_rb_pkg::CNT_W-1:0] RX_FULL_CNT =
    uart_rb_pkg::CNT_W'(uart_rb_pkg::RX_MASK);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(tx_data_o) &&
      $stable(read_data_o) && $stable(rx_available_o) && $stable(tx_space_o))
    else $error("Stalled result changed.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (uart_rb_pkg::CNT_W'(rx_available_o + rx_space_o) == RX_FULL_CNT))
    else $error("Receive count and free space disagree.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && rx_overrun_o |-> (rx_space_o == '0) && !read_valid_o)
    else $error("Overrun reported with receive space left.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && send_accepted_o |-> tx_irq_enabled_o && !tx_valid_o)
    else $error("Stored send byte left the ready interrupt off.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (tx_valid_o || (tx_data_o == '0)) && (read_valid_o || (read_data_o == '0)))
    else $error("Data shown without its valid flag.");

endmodule

bind uart_rx_tx_ring_buffers uart_rb_chk u_uart_rb_chk (.*);
